// ===== design/gtm_pkg.sv =====
package gtm_pkg;

   localparam int COEF_WIDTH  = 19;
   localparam int COEF_FRAC   = 16;
   localparam int MUL_DIGIT   = 16;
   localparam int MAG_WIDTH   = 32;
   localparam int POWER_WIDTH = 64;
   localparam int FIFO_DEPTH  = 2;

   localparam logic [POWER_WIDTH-1:0] SQRT_TOP_BIT = POWER_WIDTH'(1) << (POWER_WIDTH - 2);

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ===== design/gtm_mul.sv =====
module gtm_mul #(
   parameter int A_WIDTH = 40,
   parameter int B_WIDTH = 19
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic                              done,
   output logic signed [A_WIDTH+B_WIDTH-1:0] product
);

   localparam int DIG        = gtm_pkg::MUL_DIGIT;
   localparam int NUM_DIGITS = (B_WIDTH + DIG - 1) / DIG;
   localparam int BP_WIDTH   = NUM_DIGITS * DIG;
   localparam int SUM_WIDTH  = A_WIDTH + BP_WIDTH;
   localparam int CNT_WIDTH  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(NUM_DIGITS - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_WIDTH-1:0]        cnt_ff, cnt_in;
   logic signed [A_WIDTH-1:0]   a_ff, a_in;
   logic [BP_WIDTH-1:0]         b_ff, b_in;
   logic signed [SUM_WIDTH-1:0] acc_ff, acc_in;

   logic [DIG-1:0]              digit;
   logic signed [DIG:0]         digit_s;
   logic signed [A_WIDTH+DIG:0] partial;

   // most significant digit first, only that one carries the sign
   always_comb begin
      digit = b_ff[BP_WIDTH-1 -: DIG];
      if (cnt_ff == '0) begin
         digit_s = {digit[DIG-1], digit};
      end else begin
         digit_s = {1'b0, digit};
      end
      partial = a_ff * digit_s;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = BP_WIDTH'(b);
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< DIG) + SUM_WIDTH'(partial);
         b_in   = b_ff << DIG;
         cnt_in = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[A_WIDTH+B_WIDTH-1:0];

endmodule

// ===== design/gtm_fifo.sv =====
module gtm_fifo #(
   parameter int WIDTH = 80
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output gtm_pkg::fifo_status_type  status
);

   localparam int DEPTH     = gtm_pkg::FIFO_DEPTH;
   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== design/gtm_front.sv =====
module gtm_front #(
   parameter int ACC_WIDTH    = 40,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample,
   input  logic                                  req_last,
   input  logic signed [gtm_pkg::COEF_WIDTH-1:0] coeff,
   input  gtm_pkg::fifo_status_type              fifo_status,
   output logic                                  push,
   output logic [2*ACC_WIDTH-1:0]                push_data
);

   localparam int PROD_WIDTH = ACC_WIDTH + gtm_pkg::COEF_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH - gtm_pkg::COEF_FRAC + 2;
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_UPD  = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic signed [ACC_WIDTH-1:0]    d1_ff, d1_in;
   logic signed [ACC_WIDTH-1:0]    d2_ff, d2_in;
   logic signed [ACC_WIDTH-1:0]    next_ff, next_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                           last_ff, last_in;

   logic                              accept;
   logic                              mul_done;
   logic signed [PROD_WIDTH-1:0]      product;
   logic signed [PROD_WIDTH-1:0]      feedback;
   logic signed [SUM_WIDTH-1:0]       sum;
   logic [SUM_WIDTH-ACC_WIDTH:0]      sum_top;
   logic signed [ACC_WIDTH-1:0]       sum_sat;

   gtm_mul #(
      .A_WIDTH (ACC_WIDTH),
      .B_WIDTH (gtm_pkg::COEF_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .a       (d1_ff),
      .b       (coeff),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      req_stall = (state_ff != F_IDLE);
      accept    = req_valid && (state_ff == F_IDLE);

      // floor scaling, then saturate to the accumulator range
      feedback = product >>> gtm_pkg::COEF_FRAC;
      sum      = SUM_WIDTH'(feedback) - SUM_WIDTH'(d2_ff) + SUM_WIDTH'(sample_ff);
      sum_top  = sum[SUM_WIDTH-1:ACC_WIDTH-1];
      if ((&sum_top) || (~|sum_top)) begin
         sum_sat = sum[ACC_WIDTH-1:0];
      end else if (sum[SUM_WIDTH-1]) begin
         sum_sat = ACC_MIN;
      end else begin
         sum_sat = ACC_MAX;
      end

      push      = (state_ff == F_UPD) && last_ff && !fifo_status.full;
      push_data = {next_ff, d1_ff};

      state_in  = state_ff;
      d1_in     = d1_ff;
      d2_in     = d2_ff;
      next_in   = next_ff;
      sample_in = sample_ff;
      last_in   = last_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               last_in   = req_last;
               state_in  = F_MUL;
            end
         end
         F_MUL: begin
            if (mul_done) begin
               next_in  = sum_sat;
               state_in = F_UPD;
            end
         end
         F_UPD: begin
            if (!last_ff) begin
               d2_in    = d1_ff;
               d1_in    = next_ff;
               state_in = F_IDLE;
            end else if (!fifo_status.full) begin
               d2_in    = '0;
               d1_in    = '0;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         d1_ff    <= '0;
         d2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff   <= next_in;
      sample_ff <= sample_in;
      last_ff   <= last_in;
   end

endmodule

// ===== design/gtm_back.sv =====
module gtm_back #(
   parameter int ACC_WIDTH = 40
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [gtm_pkg::COEF_WIDTH-1:0] coeff,
   input  gtm_pkg::fifo_status_type              fifo_status,
   output logic                                  pop,
   input  logic [2*ACC_WIDTH-1:0]                pop_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [gtm_pkg::MAG_WIDTH-1:0]         rsp_magnitude
);

   localparam int BW  = ACC_WIDTH + gtm_pkg::COEF_WIDTH;
   localparam int PW  = ACC_WIDTH + BW;
   localparam int XW  = gtm_pkg::POWER_WIDTH;
   localparam int MW  = gtm_pkg::MAG_WIDTH;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_ISSUE = 3'd1;
   localparam logic [2:0] B_WAIT  = 3'd2;
   localparam logic [2:0] B_SAT   = 3'd3;
   localparam logic [2:0] B_SQRT  = 3'd4;
   localparam logic [2:0] B_OUT   = 3'd5;

   localparam logic [1:0] OP_Q1SQ = 2'd0;
   localparam logic [1:0] OP_Q2SQ = 2'd1;
   localparam logic [1:0] OP_CQ1  = 2'd2;
   localparam logic [1:0] OP_TQ2  = 2'd3;

   logic [2:0]                  state_ff, state_in;
   logic [1:0]                  op_ff, op_in;
   logic signed [ACC_WIDTH-1:0] q1_ff, q1_in;
   logic signed [ACC_WIDTH-1:0] q2_ff, q2_in;
   logic signed [BW-1:0]        t_ff, t_in;
   logic signed [PW-1:0]        pw_ff, pw_in;
   logic [XW-1:0]               x_ff, x_in;
   logic [XW-1:0]               res_ff, res_in;
   logic [XW-1:0]               bit_ff, bit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]               rsp_mag_ff, rsp_mag_in;

   logic                        mul_start;
   logic                        mul_done;
   logic signed [ACC_WIDTH-1:0] mul_a;
   logic signed [BW-1:0]        mul_b;
   logic signed [PW-1:0]        product;
   logic [XW-1:0]               root_try;
   logic                        load_out;

   gtm_mul #(
      .A_WIDTH (ACC_WIDTH),
      .B_WIDTH (BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      unique case (op_ff)
         OP_Q1SQ: begin
            mul_a = q1_ff;
            mul_b = BW'(q1_ff);
         end
         OP_Q2SQ: begin
            mul_a = q2_ff;
            mul_b = BW'(q2_ff);
         end
         OP_CQ1: begin
            mul_a = q1_ff;
            mul_b = BW'(coeff);
         end
         OP_TQ2: begin
            mul_a = q2_ff;
            mul_b = t_ff;
         end
         default: begin
            mul_a = q1_ff;
            mul_b = t_ff;
         end
      endcase
   end

   always_comb begin
      mul_start = (state_ff == B_ISSUE);
      pop       = (state_ff == B_IDLE) && !fifo_status.empty;
      root_try  = res_ff + bit_ff;
      load_out  = (state_ff == B_OUT) && (!rsp_valid_ff || !rsp_stall);

      state_in = state_ff;
      op_in    = op_ff;
      q1_in    = q1_ff;
      q2_in    = q2_ff;
      t_in     = t_ff;
      pw_in    = pw_ff;
      x_in     = x_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               q1_in    = pop_data[2*ACC_WIDTH-1:ACC_WIDTH];
               q2_in    = pop_data[ACC_WIDTH-1:0];
               op_in    = OP_Q1SQ;
               state_in = B_ISSUE;
            end
         end
         B_ISSUE: begin
            state_in = B_WAIT;
         end
         B_WAIT: begin
            if (mul_done) begin
               unique case (op_ff)
                  OP_Q1SQ: pw_in = product;
                  OP_Q2SQ: pw_in = pw_ff + product;
                  OP_CQ1:  t_in  = product[BW-1:0];
                  OP_TQ2:  pw_in = pw_ff - (product >>> gtm_pkg::COEF_FRAC);
                  default: pw_in = pw_ff;
               endcase
               if (op_ff == OP_TQ2) begin
                  state_in = B_SAT;
               end else begin
                  op_in    = op_ff + 2'd1;
                  state_in = B_ISSUE;
               end
            end
         end
         B_SAT: begin
            // negative power clamps to zero, too large saturates
            if (pw_ff[PW-1]) begin
               x_in = '0;
            end else if (|pw_ff[PW-2:XW]) begin
               x_in = '1;
            end else begin
               x_in = pw_ff[XW-1:0];
            end
            res_in   = '0;
            bit_in   = gtm_pkg::SQRT_TOP_BIT;
            state_in = B_SQRT;
         end
         B_SQRT: begin
            if (x_ff >= root_try) begin
               x_in   = x_ff - root_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (load_out) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      rsp_mag_in = rsp_mag_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_mag_in   = res_ff[MW-1:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         op_ff        <= OP_Q1SQ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q1_ff      <= q1_in;
      q2_ff      <= q2_in;
      t_ff       <= t_in;
      pw_ff      <= pw_in;
      x_ff       <= x_in;
      res_ff     <= res_in;
      bit_ff     <= bit_in;
      rsp_mag_ff <= rsp_mag_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;

endmodule

// ===== design/goertzel_tone_magnitude_core.sv =====
// Goertzel single-bin tone detector. Each request carries one signed sample; the front
// runs the recurrence q0 = floor(coeff*q1/2^16) - q2 + sample, saturated to ACC_WIDTH
// bits, and stalls further requests until it is done with a sample; it multiplies
// the coefficient by q1 as two 16-bit digits. A request marked last moves the final
// delay pair into a two-entry queue and clears the delays, so the next block starts
// from zero; while the queue is full, the front stalls.
// The back takes a pair from the queue and forms the power
// q1^2 + q2^2 - floor(coeff*q1*q2/2^16) with four passes through its own
// digit-serial multiplier, clamps it to [0, 2^64-1] and takes a 32-step floor
// square root; one response carries the magnitude per block. The coefficient is
// 2cos(omega) in signed Q2.16; the user must have it written through the csr channel
// only while idle, and the block itself does not enforce this.
module goertzel_tone_magnitude_core #(
   parameter int ACC_WIDTH    = 40,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [gtm_pkg::MAG_WIDTH-1:0]         rsp_magnitude,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic signed [gtm_pkg::COEF_WIDTH-1:0] csr_bin_coefficient
);

   logic signed [gtm_pkg::COEF_WIDTH-1:0] coeff_ff, coeff_in;

   logic                     push;
   logic [2*ACC_WIDTH-1:0]   push_data;
   logic                     pop;
   logic [2*ACC_WIDTH-1:0]   pop_data;
   gtm_pkg::fifo_status_type fifo_status;

   assign csr_ready = 1'b1;

   always_comb begin
      coeff_in = coeff_ff;
      if (csr_valid && csr_ready) begin
         coeff_in = csr_bin_coefficient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   gtm_front #(
      .ACC_WIDTH    (ACC_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .req_last    (req_last),
      .coeff       (coeff_ff),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data)
   );

   gtm_fifo #(
      .WIDTH (2*ACC_WIDTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   gtm_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .coeff         (coeff_ff),
      .fifo_status   (fifo_status),
      .pop           (pop),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude)
   );

endmodule

// ===== design/gtm_checker.sv =====
module gtm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gtm_pkg::MAG_WIDTH-1:0] rsp_magnitude
);

   // the front stalls requests while it works on an accepted sample
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on back-to-back cycles");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_magnitude))
      else $error("response changed while stalled");

endmodule

bind goertzel_tone_magnitude_core gtm_checker u_gtm_checker (.*);

// ===== tb/goertzel_tone_magnitude_core_test.sv =====
module goertzel_tone_magnitude_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACC_BITS      = 40;
   localparam int SAMPLE_BITS   = 16;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES   = 500;
   localparam int PHASE_ITEMS   = 265;
   localparam int RANDOM_PHASES = 6;

   localparam longint ACC_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

   localparam logic signed [gtm_pkg::COEF_WIDTH-1:0] COEF_PLUS_TWO  = 19'sd131072;
   localparam logic signed [gtm_pkg::COEF_WIDTH-1:0] COEF_MINUS_TWO = -19'sd131072;
   localparam logic signed [gtm_pkg::COEF_WIDTH-1:0] COEF_MOST_POS  = 19'sd262143;
   localparam logic signed [gtm_pkg::COEF_WIDTH-1:0] COEF_MOST_NEG  = 19'sh40000;

   class goertzel_bin_tracker;
      logic signed [gtm_pkg::COEF_WIDTH-1:0] coefficient;
      longint delay_one;
      longint delay_two;
      logic [gtm_pkg::MAG_WIDTH-1:0] expected_magnitudes[$];
      int mismatches;

      function new();
         coefficient = '0;
         delay_one = 0;
         delay_two = 0;
         mismatches = 0;
      endfunction

      function void load_coefficient(logic signed [gtm_pkg::COEF_WIDTH-1:0] value);
         coefficient = value;
      endfunction

      function int pending();
         return expected_magnitudes.size();
      endfunction

      function logic [gtm_pkg::MAG_WIDTH-1:0] floor_root(logic [63:0] x);
         logic [63:0] root;
         logic [63:0] trial;
         root = '0;
         for (int b = gtm_pkg::MAG_WIDTH - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
               root = trial;
            end
         end
         return root[gtm_pkg::MAG_WIDTH-1:0];
      endfunction

      function void take_sample(logic signed [SAMPLE_BITS-1:0] sample, logic last);
         longint product;
         longint next;
         logic signed [127:0] q1;
         logic signed [127:0] q2;
         logic signed [127:0] cw;
         logic signed [127:0] power;
         logic [63:0] clamped;
         product = longint'(coefficient) * delay_one;
         next = (product >>> gtm_pkg::COEF_FRAC) - delay_two + longint'(sample);
         if (next > ACC_MAX) begin
            next = ACC_MAX;
         end else if (next < ACC_MIN) begin
            next = ACC_MIN;
         end
         delay_two = delay_one;
         delay_one = next;
         if (last) begin
            q1 = delay_one;
            q2 = delay_two;
            cw = coefficient;
            power = q1 * q1 + q2 * q2 - ((cw * q1 * q2) >>> gtm_pkg::COEF_FRAC);
            if (power < 0) begin
               clamped = '0;
            end else if (power[127:64] != 0) begin
               clamped = '1;
            end else begin
               clamped = power[63:0];
            end
            expected_magnitudes.insert(expected_magnitudes.size(), floor_root(clamped));
            delay_one = 0;
            delay_two = 0;
         end
      endfunction

      function void match_magnitude(logic [gtm_pkg::MAG_WIDTH-1:0] got);
         logic [gtm_pkg::MAG_WIDTH-1:0] want;
         if (expected_magnitudes.size() == 0) begin
            mismatches++;
            $display("%0t: magnitude expected none actual %0d", $time, got);
         end else begin
            want = expected_magnitudes.pop_front();
            if (want !== got) begin
               mismatches++;
               $display("%0t: magnitude expected %0d actual %0d", $time, want, got);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic req_last;
   logic rsp_valid;
   logic rsp_stall;
   logic [gtm_pkg::MAG_WIDTH-1:0] rsp_magnitude;
   logic csr_valid;
   logic csr_ready;
   logic signed [gtm_pkg::COEF_WIDTH-1:0] csr_bin_coefficient;

   goertzel_bin_tracker tracker = new();
   int cycle_count;
   int burst_left;
   bit hold_off_requested;

   goertzel_tone_magnitude_core #(
      .ACC_WIDTH(ACC_BITS),
      .SAMPLE_WIDTH(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_magnitude(rsp_magnitude),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_bin_coefficient(csr_bin_coefficient)
   );

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.match_magnitude(rsp_magnitude);
      end
   end

   // response side stalls in segments of its own, with one long hold-off on request
   initial begin
      int seg_len;
      int stall_pct;
      int mode;
      rsp_stall = 1'b0;
      forever begin
         if (hold_off_requested) begin
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            hold_off_requested = 1'b0;
         end
         mode = $urandom_range(0, 9);
         seg_len = $urandom_range(20, 200);
         if (mode < 3) begin
            stall_pct = 0;
         end else if (mode < 7) begin
            stall_pct = 30;
         end else begin
            stall_pct = 75;
         end
         repeat (seg_len) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sample, logic last);
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample <= sample;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      tracker.take_sample(sample, last);
   endtask

   task automatic pause_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic next_slot();
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 12));
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   task automatic wait_idle();
      pause_sender(1);
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coefficient(logic signed [gtm_pkg::COEF_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_bin_coefficient <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.load_coefficient(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [gtm_pkg::COEF_WIDTH-1:0] coef;
      logic signed [SAMPLE_BITS-1:0] sample;
      int block_len;
      int sent;
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_last = 1'b0;
      csr_valid = 1'b0;
      csr_bin_coefficient = '0;
      burst_left = 0;
      hold_off_requested = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficient, single-sample blocks at the sample extremes and zero, then a two-sample block
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample('0, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b1);

      // coefficient of -4 drives the delays and the power into saturation
      wait_idle();
      write_coefficient(COEF_MOST_NEG);
      for (int i = 0; i < 16; i++) begin
         send_sample(SAMPLE_MAX, i == 15);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: coef = COEF_PLUS_TWO;
            1: coef = COEF_MINUS_TWO;
            2: coef = COEF_MOST_POS;
            3: coef = gtm_pkg::COEF_WIDTH'($urandom);
            default: coef = gtm_pkg::COEF_WIDTH'($urandom_range(0, 262143)) - COEF_PLUS_TWO;
         endcase
         write_coefficient(coef);
         if (phase == 0) begin
            hold_off_requested = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               block_len = $urandom_range(1, 16);
            end else if (pick < 9) begin
               block_len = $urandom_range(17, 48);
            end else begin
               block_len = $urandom_range(49, 120);
            end
            for (int i = 0; i < block_len; i++) begin
               next_slot();
               if ($urandom_range(0, 4) == 0) begin
                  sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
               end else begin
                  sample = SAMPLE_BITS'($urandom);
               end
               send_sample(sample, i == block_len - 1);
            end
            sent += block_len;
         end
      end

      wait_idle();
      if (tracker.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
